// File: rtl/sbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite bitmap pixel emitter package
// Shared widths, result kinds and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sbpe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned BIT_CNT_W = 3;
  localparam int unsigned SUB_W     = 2;

  localparam int unsigned SCALE_OFFSET_X_DEF = 24;
  localparam int unsigned SCALE_OFFSET_Y_DEF = 11;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BYTE_W - 1);
  localparam logic [SUB_W-1:0]     SUB_LAST = '1;

  typedef enum logic {
    KIND_PIXEL   = 1'b0,
    KIND_PRESENT = 1'b1
  } kind_t;

  typedef struct packed {
    logic             load;
    logic             advance;
    logic             emit;
    logic             present;
    logic             final_px;
    logic [SUB_W-1:0] sub;
  } sbpe_cmd_t;

  typedef struct packed {
    logic cur_bit;
    logic more_bits;
    logic doubled;
    logic last_byte;
    logic out_free;
  } sbpe_sts_t;

endpackage
`default_nettype wire

// File: rtl/sprite_bitmap_pixel_emitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite bitmap pixel emitter
// Turns a one-bit sprite, fed a byte per item, into pixel write items
// at scale one or as 2x2 blocks at a fixed offset, and a present item after
// the final byte. The controller takes a byte in its idle state and then
// steps one bit per cycle unless a set bit waits for the output register;
// it is ready for a new byte only after all eight bits. A set bit at scale
// one is written as it steps; in a doubled draw each set bit holds the step
// for the remaining writes of its block; a final byte adds the present item.
// The single output register sets the pace whenever the receiver stalls.
// ----------------------------------------------------------------------------
module sprite_bitmap_pixel_emitter_core #(
  parameter int unsigned SCALE_OFFSET_X = sbpe_pkg::SCALE_OFFSET_X_DEF,
  parameter int unsigned SCALE_OFFSET_Y = sbpe_pkg::SCALE_OFFSET_Y_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,  // scale_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // sprite_byte, pos_x, pos_y, sprite_width
  input  wire logic [1:0]  in_tuser,     // command, first_byte
  input  wire logic        in_tlast,     // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,    // pixel_x, pixel_y, zero pad
  output logic [0:0]       out_tuser,    // kind
  output logic             out_tlast     // last
);
  import sbpe_pkg::*;

  sbpe_cmd_t          cmd;
  sbpe_sts_t          sts;
  logic               out_kind;
  logic [COORD_W-1:0] out_pixel_x, out_pixel_y;

  sbpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbpe_datapath #(
    .SCALE_OFFSET_X (SCALE_OFFSET_X),
    .SCALE_OFFSET_Y (SCALE_OFFSET_Y)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_command      (in_tuser[0]),
    .in_sprite_byte  (in_tdata[7:0]),
    .in_pos_x        (in_tdata[15:8]),
    .in_pos_y        (in_tdata[23:16]),
    .in_sprite_width (in_tdata[31:24]),
    .in_first_byte   (in_tuser[1]),
    .in_last_byte    (in_tlast),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_kind        (out_kind),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_last        (out_tlast)
  );

  assign out_tdata = {4'b0000, out_pixel_y, out_pixel_x};
  assign out_tuser = out_kind;

endmodule
`default_nettype wire

// File: rtl/sbpe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite bitmap pixel emitter controller
// Walks the eight bits of a byte, the four writes of a doubled pixel and the
// trailing present item, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module sbpe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbpe_pkg::sbpe_sts_t sts,
  output sbpe_pkg::sbpe_cmd_t    cmd
);
  import sbpe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_PRESENT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [SUB_W-1:0]       sub_r, sub_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    logic step;
    step        = 1'b0;
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    sub_nxt     = sub_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          state_nxt   = ST_BITS;
          bit_cnt_nxt = '0;
          sub_nxt     = '0;
        end
      end
      ST_BITS: begin
        if (sts.cur_bit) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.sub      = sub_r;
            cmd.final_px = !sts.more_bits && !sts.last_byte &&
                           (!sts.doubled || (sub_r == SUB_LAST));
            if (sts.doubled && (sub_r != SUB_LAST)) begin
              sub_nxt = sub_r + SUB_W'(1);
            end else begin
              step = 1'b1;
            end
          end
        end else begin
          step = 1'b1;
        end
        if (step) begin
          cmd.advance = 1'b1;
          sub_nxt     = '0;
          bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
          if (bit_cnt_r == BIT_LAST) begin
            state_nxt = sts.last_byte ? ST_PRESENT : ST_IDLE;
          end
        end
      end
      ST_PRESENT: begin
        if (sts.out_free) begin
          cmd.present = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      sub_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      sub_r     <= sub_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!cmd.emit && !cmd.present && !cmd.advance))
    else $error("controller drives datapath while idle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.present) |-> sts.out_free)
    else $error("item written into an occupied output register");

  a_sub_doubled: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != '0) |-> (sts.doubled && (state_r == ST_BITS)))
    else $error("block index moved outside a doubled draw");

  a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_BITS) && (bit_cnt_r == BIT_LAST) && cmd.advance && !sts.last_byte)
    |=> in_ready)
    else $error("byte finished without returning to ready");
`endif

endmodule
`default_nettype wire

// File: rtl/sbpe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite bitmap pixel emitter datapath
// Holds the byte shift register, sprite geometry, column and row counters,
// scale mode and the output register with its coordinate adders.
// ----------------------------------------------------------------------------
module sbpe_datapath #(
  parameter int unsigned SCALE_OFFSET_X = sbpe_pkg::SCALE_OFFSET_X_DEF,
  parameter int unsigned SCALE_OFFSET_Y = sbpe_pkg::SCALE_OFFSET_Y_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic                        in_command,
  input  wire logic [sbpe_pkg::BYTE_W-1:0] in_sprite_byte,
  input  wire logic [sbpe_pkg::BYTE_W-1:0] in_pos_x,
  input  wire logic [sbpe_pkg::BYTE_W-1:0] in_pos_y,
  input  wire logic [sbpe_pkg::BYTE_W-1:0] in_sprite_width,
  input  wire logic                        in_first_byte,
  input  wire logic                        in_last_byte,
  input  wire sbpe_pkg::sbpe_cmd_t         cmd,
  output sbpe_pkg::sbpe_sts_t              sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_kind,
  output logic [sbpe_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [sbpe_pkg::COORD_W-1:0]     out_pixel_y,
  output logic                             out_last
);
  import sbpe_pkg::*;

  logic                scale_mode_r;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [BYTE_W-1:0]   px_r, py_r, width_r;
  logic                doubled_r, last_byte_r;
  logic [BYTE_W-1:0]   column_r, column_nxt;
  logic [BYTE_W-1:0]   row_r, row_nxt;
  logic [BYTE_W:0]     col_inc;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_last_r;
  logic [COORD_W-1:0]  out_x_r, out_y_r;
  logic [COORD_W-1:0]  pix_x, pix_y;

  assign sts.cur_bit   = shift_r[0];
  assign sts.more_bits = |shift_r[BYTE_W-1:1];
  assign sts.doubled   = doubled_r;
  assign sts.last_byte = last_byte_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Step column and row
  assign col_inc = {1'b0, column_r} + (BYTE_W+1)'(1);

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    shift_nxt  = shift_r;
    if (cmd.load) begin
      shift_nxt = in_sprite_byte;
      if (in_first_byte) begin
        column_nxt = '0;
        row_nxt    = '0;
      end
    end else if (cmd.advance) begin
      shift_nxt = {1'b0, shift_r[BYTE_W-1:1]};
      if (col_inc >= {1'b0, width_r}) begin
        column_nxt = '0;
        row_nxt    = row_r + BYTE_W'(1);
      end else begin
        column_nxt = col_inc[BYTE_W-1:0];
      end
    end
  end

  // Pixel coordinates
  always_comb begin
    if (doubled_r) begin
      pix_x = COORD_W'(SCALE_OFFSET_X) + COORD_W'(px_r) + {1'b0, column_r, 1'b0}
              + COORD_W'(cmd.sub[0]);
      pix_y = COORD_W'(SCALE_OFFSET_Y) + COORD_W'(py_r) + {1'b0, row_r, 1'b0}
              + COORD_W'(cmd.sub[1]);
    end else begin
      pix_x = COORD_W'(px_r) + COORD_W'(column_r);
      pix_y = COORD_W'(py_r) + COORD_W'(row_r);
    end
  end

  always_comb begin
    if (cmd.emit || cmd.present) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= 1'b0;
      column_r     <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_mode_r <= cfg_wr_data;
      end
      column_r    <= column_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (cmd.load) begin
      px_r        <= in_pos_x;
      py_r        <= in_pos_y;
      width_r     <= in_sprite_width;
      doubled_r   <= !in_command && scale_mode_r;
      last_byte_r <= in_last_byte;
    end
    if (cmd.emit) begin
      out_kind_r <= KIND_PIXEL;
      out_x_r    <= pix_x;
      out_y_r    <= pix_y;
      out_last_r <= cmd.final_px;
    end else if (cmd.present) begin
      out_kind_r <= KIND_PRESENT;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_present_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_PRESENT))
    |-> (out_last_r && (out_x_r == '0) && (out_y_r == '0)))
    else $error("present item with coordinates or without last");

  a_emit_set_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> shift_r[0])
    else $error("pixel written for a clear bit");

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.advance) && (width_r != '0)) |-> (column_r < width_r))
    else $error("column left the sprite width");
`endif

endmodule
`default_nettype wire
